// File: src/whs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package whs_pkg;

  localparam int unsigned WordBits = 160;
  localparam int unsigned FullBytes = 20;

  // A packed word compares as one unsigned 160-bit number, first character on top.
  typedef struct packed {
    logic [63:0] high;
    logic [63:0] mid;
    logic [31:0] low;
  } whs_word_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_LOAD,
    OP_SORT,
    OP_DRAIN
  } whs_op_e;

  typedef struct packed {
    whs_op_e op;
    logic    odd_phase;
  } whs_ctrl_t;

endpackage

`default_nettype wire

// File: src/word_heap_sorter_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Sorts a set of up to MAX_WORDS packed words and returns them in ascending order.
// Words are loaded one beat per cycle into a row of cells; the beat marked is_last
// closes the set, and words arriving while the row is full are dropped and reported
// through overflowed on every result of that set. Once the set is closed the row runs
// n odd-even exchange phases (n = stored words), each cell comparing its 160-bit word
// with a neighbor, and then shifts the words out of the head cell one result beat per
// cycle while out_stall_i is low, final_word marking the largest. Per word the set
// thus goes through a load beat, an exchange phase and a result beat. The input is
// stalled from the beat that closes a set until the last result of that set has left
// the row.
module word_heap_sorter_unit #(
  parameter int unsigned MAX_WORDS  = 64,
  parameter int unsigned WORD_BYTES = 20
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [63:0] chars_0_to_7_i,
  input  wire  [63:0] chars_8_to_15_i,
  input  wire  [31:0] chars_16_to_19_i,
  input  wire         is_last_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [63:0] out_chars_0_to_7_o,
  output logic [63:0] out_chars_8_to_15_o,
  output logic [31:0] out_chars_16_to_19_o,
  output logic        final_word_o,
  output logic        overflowed_o
);
  import whs_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WORDS + 1);

  typedef enum logic [2:0] {
    ST_LOAD  = 3'b001,
    ST_SORT  = 3'b010,
    ST_DRAIN = 3'b100
  } state_e;

  state_e              state_q, state_d;
  logic [CW-1:0]       count_q, count_d;
  logic [CW-1:0]       phase_q, phase_d;
  logic                dropped_q, dropped_d;
  logic                out_valid_q, out_valid_d;
  whs_word_t           out_word_q, out_word_d;
  logic                out_final_q, out_final_d;
  logic                out_ovf_q, out_ovf_d;

  whs_ctrl_t           ctrl;
  whs_word_t           in_word;
  logic [WordBits-1:0] keep_mask;
  logic                in_accept;
  logic                load_out;
  logic                full;

  whs_word_t             cell_word [MAX_WORDS];
  logic [MAX_WORDS-1:0]  cell_swap;
  logic [MAX_WORDS-1:0]  in_use;

  // Bytes past WORD_BYTES are cleared on the way in.
  always_comb begin
    keep_mask = '0;
    for (int k = 0; k < FullBytes; k++) begin
      keep_mask[WordBits-1-8*k -: 8] = (k < WORD_BYTES) ? 8'hFF : 8'h00;
    end
  end

  assign in_word   = whs_word_t'({chars_0_to_7_i, chars_8_to_15_i, chars_16_to_19_i} &
                                 keep_mask);
  assign in_stall_o = (state_q != ST_LOAD);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign full       = (count_q == CW'(MAX_WORDS));
  assign load_out   = (state_q == ST_DRAIN) && (count_q != '0) &&
                      (!out_valid_q || !out_stall_i);

  for (genvar g = 0; g < MAX_WORDS; g++) begin : g_cell
    whs_word_t lower;
    whs_word_t upper;
    logic      lower_swap;
    logic      upper_used;

    assign in_use[g] = (count_q > CW'(g));

    if (g == 0) begin : g_head
      assign lower      = in_word;
      assign lower_swap = 1'b0;
    end else begin : g_body
      assign lower      = cell_word[g-1];
      assign lower_swap = cell_swap[g-1];
    end

    if (g == MAX_WORDS - 1) begin : g_tail
      assign upper      = '0;
      assign upper_used = 1'b0;
    end else begin : g_inner
      assign upper      = cell_word[g+1];
      assign upper_used = in_use[g+1];
    end

    whs_cell #(
      .IS_ODD (1'(g % 2))
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .lower_i      (lower),
      .upper_i      (upper),
      .lower_swap_i (lower_swap),
      .upper_used_i (upper_used),
      .word_o       (cell_word[g]),
      .swap_o       (cell_swap[g])
    );
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    phase_d     = phase_q;
    dropped_d   = dropped_q;
    ctrl.op        = OP_HOLD;
    ctrl.odd_phase = phase_q[0];
    out_word_d  = out_word_q;
    out_final_d = out_final_q;
    out_ovf_d   = out_ovf_q;
    out_valid_d = out_valid_q && out_stall_i;

    case (state_q)
      ST_LOAD: begin
        if (in_accept) begin
          if (!full) begin
            ctrl.op = OP_LOAD;
            count_d = count_q + 1'b1;
          end else begin
            dropped_d = 1'b1;
          end
          if (is_last_i) begin
            state_d = ST_SORT;
            phase_d = '0;
          end
        end
      end
      ST_SORT: begin
        // n exchange phases leave n words fully ordered.
        ctrl.op = OP_SORT;
        phase_d = phase_q + 1'b1;
        if (phase_q == CW'(count_q - 1'b1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (load_out) begin
          ctrl.op     = OP_DRAIN;
          out_word_d  = cell_word[0];
          out_final_d = (count_q == CW'(1));
          out_ovf_d   = dropped_q;
          out_valid_d = 1'b1;
          count_d     = count_q - 1'b1;
          if (count_q == CW'(1)) begin
            dropped_d = 1'b0;
            state_d   = ST_LOAD;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      count_q     <= '0;
      phase_q     <= '0;
      dropped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      phase_q     <= phase_d;
      dropped_q   <= dropped_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q  <= out_word_d;
    out_final_q <= out_final_d;
    out_ovf_q   <= out_ovf_d;
  end

  assign out_valid_o          = out_valid_q;
  assign out_chars_0_to_7_o   = out_word_q.high;
  assign out_chars_8_to_15_o  = out_word_q.mid;
  assign out_chars_16_to_19_o = out_word_q.low;
  assign final_word_o         = out_final_q;
  assign overflowed_o         = out_ovf_q;

  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_WORDS))
    else $error("word count exceeds capacity");

  a_busy_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SORT || state_q == ST_DRAIN) |-> count_q != '0)
    else $error("sort or drain with no stored words");

  a_head_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN && count_q > CW'(1)) |-> !(cell_word[0] > cell_word[1]))
    else $error("head cell larger than its neighbor after sorting");

  a_drop_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD && dropped_q) |-> full)
    else $error("word dropped while the row had room");

endmodule

`default_nettype wire

// File: src/whs_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module whs_cell #(
  parameter bit IS_ODD = 1'b0
) (
  input  wire                 clk_i,
  input  whs_pkg::whs_ctrl_t  ctrl_i,
  input  whs_pkg::whs_word_t  lower_i,
  input  whs_pkg::whs_word_t  upper_i,
  input  wire                 lower_swap_i,
  input  wire                 upper_used_i,
  output whs_pkg::whs_word_t  word_o,
  output logic                swap_o
);
  import whs_pkg::*;

  whs_word_t word_q;
  whs_word_t word_d;
  logic      low_role;

  // In an even phase the pairs start at even cells, in an odd phase at odd cells.
  assign low_role = (IS_ODD == ctrl_i.odd_phase);
  assign swap_o   = (ctrl_i.op == OP_SORT) && low_role && upper_used_i &&
                    (word_q > upper_i);
  assign word_o   = word_q;

  always_comb begin
    word_d = word_q;
    case (ctrl_i.op)
      OP_HOLD:  word_d = word_q;
      OP_LOAD:  word_d = lower_i;
      OP_DRAIN: word_d = upper_i;
      OP_SORT: begin
        if (swap_o) begin
          word_d = upper_i;
        end else if (!low_role && lower_swap_i) begin
          word_d = lower_i;
        end
      end
      default:  word_d = word_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

endmodule

`default_nettype wire

// File: tb/word_heap_sorter_unit_checker.sv
`timescale 1ns / 1ps

module word_heap_sorter_unit_checker
  import whs_pkg::*;
#(
  parameter int unsigned MAX_WORDS  = 64,
  parameter int unsigned WORD_BYTES = 20
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  input  wire         in_stall_i,
  input  wire  [63:0] chars_0_to_7_i,
  input  wire  [63:0] chars_8_to_15_i,
  input  wire  [31:0] chars_16_to_19_i,
  input  wire         is_last_i,
  input  wire         out_valid_i,
  input  wire         out_stall_i,
  input  wire  [63:0] out_chars_0_to_7_i,
  input  wire  [63:0] out_chars_8_to_15_i,
  input  wire  [31:0] out_chars_16_to_19_i,
  input  wire         final_word_i,
  input  wire         overflowed_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  typedef struct packed {
    whs_word_t word;
    logic      final_word;
    logic      overflowed;
  } sorted_beat_t;

  whs_word_t    stored_words [MAX_WORDS];
  int unsigned  stored_count  = 0;
  logic         words_dropped = 1'b0;
  sorted_beat_t sorted_words_due [$];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  // The block keeps only WORD_BYTES bytes; the trailing ones read as zero.
  function automatic whs_word_t keep_bytes(input whs_word_t w);
    logic [159:0] v;
    v = w;
    for (int k = WORD_BYTES; k < 20; k++) v[159 - 8 * k -: 8] = 8'h00;
    return v;
  endfunction

  // Ascending order of the stored words as unsigned 160-bit numbers. Any correct
  // sort gives the same sequence, since equal words are indistinguishable.
  task automatic sort_stored_words();
    int        j;
    whs_word_t key;
    for (int i = 1; i < int'(stored_count); i++) begin
      key = stored_words[i];
      j   = i - 1;
      while (j >= 0 && stored_words[j] > key) begin
        stored_words[j + 1] = stored_words[j];
        j--;
      end
      stored_words[j + 1] = key;
    end
  endtask

  always @(posedge clk_i) begin : watch
    sorted_beat_t got;
    sorted_beat_t want;
    logic         differs;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        got = {out_chars_0_to_7_i, out_chars_8_to_15_i, out_chars_16_to_19_i,
               final_word_i, overflowed_i};
        if (sorted_words_due.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("%0t: result beat with nothing pending: %h %h %h final=%b ovf=%b",
                     $realtime, got.word.high, got.word.mid, got.word.low,
                     got.final_word, got.overflowed);
        end else begin
          want    = sorted_words_due.pop_front();
          differs = (got.word.high !== want.word.high) ||
                    (got.word.mid !== want.word.mid) ||
                    (got.word.low !== want.word.low) ||
                    (got.final_word !== want.final_word) ||
                    (got.overflowed !== want.overflowed);
          if (differs) begin
            fail_count_o++;
            if (fail_count_o <= 10) begin
              $display("%0t: expected %h %h %h final=%b ovf=%b", $realtime,
                       want.word.high, want.word.mid, want.word.low,
                       want.final_word, want.overflowed);
              $display("%0t: actual   %h %h %h final=%b ovf=%b", $realtime,
                       got.word.high, got.word.mid, got.word.low,
                       got.final_word, got.overflowed);
            end
          end
        end
      end

      if (in_valid_i && !in_stall_i) begin
        if (stored_count < MAX_WORDS) begin
          stored_words[stored_count] =
            keep_bytes({chars_0_to_7_i, chars_8_to_15_i, chars_16_to_19_i});
          stored_count++;
        end else begin
          words_dropped = 1'b1;
        end
        // The closing beat triggers the output even when it was itself dropped.
        if (is_last_i) begin
          sort_stored_words();
          for (int k = 0; k < int'(stored_count); k++) begin
            want.word       = stored_words[k];
            want.final_word = (k + 1 == int'(stored_count));
            want.overflowed = words_dropped;
            sorted_words_due.push_back(want);
          end
          stored_count  = 0;
          words_dropped = 1'b0;
        end
      end
      pending_o = sorted_words_due.size();
    end
  end

endmodule

// File: tb/word_heap_sorter_unit_test.sv
`timescale 1ns / 1ps

module word_heap_sorter_unit_test;
  import whs_pkg::*;

  localparam int unsigned MaxWords   = 64;
  localparam int unsigned WordBytes  = 20;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned ItemTarget = 500;

  logic        clk_i      = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_valid   = 1'b0;
  logic        in_stall;
  logic [63:0] word_hi    = '0;
  logic [63:0] word_mid   = '0;
  logic [31:0] word_lo    = '0;
  logic        word_last  = 1'b0;
  logic        out_valid;
  logic        out_stall  = 1'b0;
  logic [63:0] sorted_hi;
  logic [63:0] sorted_mid;
  logic [31:0] sorted_lo;
  logic        sorted_final;
  logic        sorted_ovf;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count = 0;
  int unsigned items_sent  = 0;
  logic        calm        = 1'b0;
  logic        beat_out    = 1'b0;

  always #4 clk_i = ~clk_i;

  word_heap_sorter_unit #(
    .MAX_WORDS (MaxWords),
    .WORD_BYTES(WordBytes)
  ) uut (
    .clk_i               (clk_i),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .chars_0_to_7_i      (word_hi),
    .chars_8_to_15_i     (word_mid),
    .chars_16_to_19_i    (word_lo),
    .is_last_i           (word_last),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .out_chars_0_to_7_o  (sorted_hi),
    .out_chars_8_to_15_o (sorted_mid),
    .out_chars_16_to_19_o(sorted_lo),
    .final_word_o        (sorted_final),
    .overflowed_o        (sorted_ovf)
  );

  word_heap_sorter_unit_checker #(
    .MAX_WORDS (MaxWords),
    .WORD_BYTES(WordBytes)
  ) sort_check (
    .clk_i               (clk_i),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_stall_i          (in_stall),
    .chars_0_to_7_i      (word_hi),
    .chars_8_to_15_i     (word_mid),
    .chars_16_to_19_i    (word_lo),
    .is_last_i           (word_last),
    .out_valid_i         (out_valid),
    .out_stall_i         (out_stall),
    .out_chars_0_to_7_i  (sorted_hi),
    .out_chars_8_to_15_i (sorted_mid),
    .out_chars_16_to_19_i(sorted_lo),
    .final_word_i        (sorted_final),
    .overflowed_i        (sorted_ovf),
    .fail_count_o        (fail_count),
    .pending_o           (pending)
  );

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // After every result beat the receiver holds off for a random number of cycles.
  always @(posedge clk_i) beat_out <= out_valid && !out_stall;

  always @(negedge clk_i) begin : result_hold
    int hold_left;
    if (beat_out) hold_left = calm ? 0 : $urandom_range(0, 4);
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic whs_word_t text_word(input string s);
    logic [159:0] v;
    v = '0;
    for (int k = 0; k < s.len() && k < 20; k++) v[159 - 8 * k -: 8] = s[k];
    return v;
  endfunction

  // Mix of raw random words, short lowercase strings, near neighbors of the
  // previous word and exact repeats, so the compare sees every kind of tie.
  function automatic whs_word_t make_word(input whs_word_t prev);
    logic [159:0] v;
    int           len;
    int           cut;
    int           pos;
    v = prev;
    case ($urandom_range(0, 9))
      0, 1, 2: v = {$urandom, $urandom, $urandom, $urandom, $urandom};
      3, 4, 5: begin
        v   = '0;
        len = $urandom_range(1, 20);
        for (int k = 0; k < len; k++) v[159 - 8 * k -: 8] = 8'h61 + 8'($urandom_range(0, 25));
        if ($urandom_range(0, 3) == 0) begin
          pos = $urandom_range(0, len - 1);
          v[159 - 8 * pos -: 8] = 8'h00;
        end
      end
      6, 7: begin
        cut = $urandom_range(0, 19);
        for (int k = cut; k < 20; k++) v[159 - 8 * k -: 8] = 8'($urandom);
      end
      8: v = prev;
      default: v = $urandom_range(0, 1) ? '1 : '0;
    endcase
    return v;
  endfunction

  task automatic send_word(input whs_word_t w, input logic last);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid  <= 1'b1;
    word_hi   <= w.high;
    word_mid  <= w.mid;
    word_lo   <= w.low;
    word_last <= last;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    items_sent++;
  endtask

  // Stop sending and let every pending result drain out.
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin : stimulus
    whs_word_t    w;
    whs_word_t    prev;
    int unsigned  set_size;
    int unsigned  pick;
    logic         first_set;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;

    // Single-word sets at both extremes.
    send_word('1, 1'b1);
    send_word('0, 1'b1);

    // Zero byte inside a word, equal words, and words that differ only low down.
    send_word(text_word("ab"), 1'b0);
    w = text_word("ab");
    w[159 - 24 -: 8] = "c";
    send_word(w, 1'b0);
    send_word(text_word("abc"), 1'b0);
    send_word(text_word("abc"), 1'b0);
    send_word('1, 1'b0);
    send_word('0, 1'b0);
    send_word({64'h0, 64'h1, 32'h0}, 1'b0);
    send_word({64'h0, 64'h0, 32'h1}, 1'b0);
    send_word({64'h1, 64'h0, 32'h0}, 1'b1);

    send_word(text_word("zzzz"), 1'b0);
    send_word(text_word("yy"), 1'b0);
    send_word(text_word("m"), 1'b0);
    send_word(text_word("b"), 1'b0);
    send_word(text_word("a"), 1'b1);

    send_word(text_word("apple"), 1'b0);
    send_word(text_word("apply"), 1'b0);
    send_word(text_word("b"), 1'b0);
    send_word(text_word("ba"), 1'b1);

    wait_drained();

    prev      = '0;
    first_set = 1'b1;
    while (items_sent < ItemTarget) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) set_size = $urandom_range(1, 8);
      else if (pick < 85) set_size = $urandom_range(9, 20);
      else if (pick < 92) set_size = $urandom_range(MaxWords - 1, MaxWords);
      else set_size = $urandom_range(MaxWords + 1, MaxWords + 4);
      calm = ($urandom_range(0, 3) == 0);
      for (int unsigned i = 0; i < set_size; i++) begin
        w    = make_word(prev);
        prev = w;
        send_word(w, i + 1 == set_size);
      end
      if (first_set || $urandom_range(0, 3) == 0) wait_drained();
      first_set = 1'b0;
    end

    wait_drained();
    repeat (50) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
